// ----- rtl/core/ita_pkg.sv -----
// shared types, constants and helpers for the integer to ascii formatter
// used by the microcode rom, the datapath and the top level; no dependencies
package ita_pkg;

    localparam int PTR_BITS = 64;
    localparam int VAL_W    = 64;
    localparam int OP_W     = 3;
    localparam int CHAR_W   = 8;
    localparam int CNT_W    = 5;
    localparam int DIG_W    = 4;
    localparam int DEPTH    = 16;
    localparam int DEPTH_W  = 5;
    localparam int UPC_W    = 4;
    localparam int Q_W      = 29;

    localparam logic [VAL_W-1:0] PTR_MASK = {VAL_W{1'b1}} >> (VAL_W - PTR_BITS);
    // ceil(2^35 / 10), exact quotient for every 32-bit dividend
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

    // format operations
    localparam logic [OP_W-1:0] OP_SDEC      = 3'd0;
    localparam logic [OP_W-1:0] OP_UDEC      = 3'd1;
    localparam logic [OP_W-1:0] OP_HEX_LOWER = 3'd2;
    localparam logic [OP_W-1:0] OP_HEX_UPPER = 3'd3;
    localparam logic [OP_W-1:0] OP_POINTER   = 3'd4;

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_X      = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_N      = 8'h6e;
    localparam logic [CHAR_W-1:0] CH_I      = 8'h69;
    localparam logic [CHAR_W-1:0] CH_L      = 8'h6c;
    localparam logic [CHAR_W-1:0] CH_A_LOW  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_A_UP   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;

    typedef logic [UPC_W-1:0] upc_t;

    // microcode addresses
    localparam upc_t UA_FETCH    = 4'd0;
    localparam upc_t UA_SDEC     = 4'd1;
    localparam upc_t UA_DEC_MUL  = 4'd2;
    localparam upc_t UA_DEC_DIG  = 4'd3;
    localparam upc_t UA_HEX      = 4'd4;
    localparam upc_t UA_EMIT_DIG = 4'd5;
    localparam upc_t UA_PTR      = 4'd6;
    localparam upc_t UA_PTR_0    = 4'd7;
    localparam upc_t UA_PTR_X    = 4'd8;
    localparam upc_t UA_NIL_0    = 4'd9;
    localparam upc_t UA_NIL_1    = 4'd10;
    localparam upc_t UA_NIL_2    = 4'd11;
    localparam upc_t UA_NIL_3    = 4'd12;
    localparam upc_t UA_NIL_4    = 4'd13;

    typedef enum logic [2:0] {
        ACT_FETCH,
        ACT_EMIT_CHR,
        ACT_BR_ZERO,
        ACT_DEC_MUL,
        ACT_DEC_DIG,
        ACT_HEX_DIG,
        ACT_EMIT_DIG
    } act_t;

    typedef struct packed {
        act_t              act;
        logic              only_neg;  // emit only when the value was negative
        logic              last;      // constant char closes the run
        logic [CHAR_W-1:0] chr;
        upc_t              nxt;
        upc_t              alt;       // branch / loop target
    } uword_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic ddig;
        logic hdig;
        logic pop;
    } dp_ctrl_t;

    typedef struct packed {
        logic              neg;
        logic              v_zero;
        logic              q_nz;
        logic              hex_more;
        logic              depth_one;
        logic [CHAR_W-1:0] dig_char;
    } dp_stat_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] base;
        base = upper ? CH_A_UP : CH_A_LOW;
        if (d < 4'd10) begin
            digit_char = CH_ZERO + {4'b0000, d};
        end else begin
            digit_char = base + {4'b0000, d} - 8'd10;
        end
    endfunction

endpackage

// ----- rtl/core/integer_to_ascii_formatter.sv -----
// top level of the integer to ascii formatter: microcode sequencer,
// output register; depends on ita_pkg, ita_urom and ita_dpath
//
// usage
//   input stream s_*: one transfer carries a format operation in s_tuser and
//   a number in s_tdata; operations are signed decimal, unsigned decimal,
//   hex lower, hex upper and pointer ("0x" plus hex digits, or "(nil)")
//   output stream m_*: one transfer per ascii character, m_tlast on the
//   final character, which also carries the character count in m_tdata
//   an undefined operation is taken and produces no transfer
//   steps: a fetch step takes the item, then one step per constant
//   character or zero test (the minus step of signed decimal is always
//   run), one step per hex digit or a multiply and a digit step per
//   decimal digit for extraction (the shared divide-by-ten reciprocal
//   multiplier), then one emit step per digit transfer
//   the next item is taken once the last character sits in the output
//   register, so that transfer overlaps the next item's work
//   a stalled receiver (m_tready low) holds the output register and the
//   sequencer waits on the current emit step; nothing is dropped
//   reset (aresetn low, synchronous) returns the step counter to fetch and
//   empties the output register
module integer_to_ascii_formatter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] value
    input  logic [2:0]  s_tuser,   // [2:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] character, [12:8] char_count, rest zero
    output logic        m_tlast
);
    import ita_pkg::*;

    // sequencer state
    upc_t               upc_reg, upc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    // output register
    logic               m_tvalid_reg, m_tvalid_next;
    logic [CHAR_W-1:0]  m_char_reg,   m_char_next;
    logic [CNT_W-1:0]   m_cnt_reg,    m_cnt_next;
    logic               m_tlast_reg,  m_tlast_next;

    uword_t             uw;
    dp_ctrl_t           ctrl;
    dp_stat_t           stat;

    logic [OP_W-1:0]    op_in;
    logic [VAL_W-1:0]   value_in;
    logic               slot_free;
    logic               emit;
    logic               emit_last;
    logic [CHAR_W-1:0]  emit_char;
    upc_t               entry;

    assign op_in    = s_tuser[OP_W-1:0];
    assign value_in = s_tdata[VAL_W-1:0];

    // output slot is free when empty or being drained this cycle
    assign slot_free = !m_tvalid_reg || m_tready;

    ita_urom u_urom (
        .addr  (upc_reg),
        .uword (uw)
    );

    ita_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .op_in    (op_in),
        .value_in (value_in),
        .stat     (stat)
    );

    // entry point of each format's microprogram
    always_comb begin
        case (op_in)
            OP_SDEC:      entry = UA_SDEC;
            OP_UDEC:      entry = UA_DEC_MUL;
            OP_HEX_LOWER: entry = UA_HEX;
            OP_HEX_UPPER: entry = UA_HEX;
            OP_POINTER:   entry = UA_PTR;
            default:      entry = UA_FETCH;
        endcase
    end

    // next step
    always_comb begin
        upc_next = upc_reg;
        case (uw.act)
            ACT_FETCH: begin
                if (s_tvalid) begin
                    upc_next = entry;
                end
            end
            ACT_EMIT_CHR: begin
                if ((uw.only_neg && !stat.neg) || slot_free) begin
                    upc_next = uw.nxt;
                end
            end
            ACT_BR_ZERO: begin
                upc_next = stat.v_zero ? uw.alt : uw.nxt;
            end
            ACT_DEC_MUL: begin
                upc_next = uw.nxt;
            end
            ACT_DEC_DIG: begin
                upc_next = stat.q_nz ? uw.alt : uw.nxt;
            end
            ACT_HEX_DIG: begin
                upc_next = stat.hex_more ? uw.alt : uw.nxt;
            end
            ACT_EMIT_DIG: begin
                if (slot_free && stat.depth_one) begin
                    upc_next = uw.nxt;
                end
            end
            default: begin
                upc_next = UA_FETCH;
            end
        endcase
    end

    // control outputs of the current step
    always_comb begin
        s_tready  = (uw.act == ACT_FETCH);
        ctrl.load = (uw.act == ACT_FETCH) && s_tvalid;
        ctrl.mul  = (uw.act == ACT_DEC_MUL);
        ctrl.ddig = (uw.act == ACT_DEC_DIG);
        ctrl.hdig = (uw.act == ACT_HEX_DIG);
        ctrl.pop  = (uw.act == ACT_EMIT_DIG) && slot_free;
        emit      = ((uw.act == ACT_EMIT_CHR) && (!uw.only_neg || stat.neg) && slot_free)
                 || ctrl.pop;
        emit_last = (uw.act == ACT_EMIT_CHR) ? uw.last : stat.depth_one;
        emit_char = (uw.act == ACT_EMIT_CHR) ? uw.chr : stat.dig_char;
    end

    // character counter and output register
    always_comb begin
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        m_char_next   = m_char_reg;
        m_cnt_next    = m_cnt_reg;
        m_tlast_next  = m_tlast_reg;
        if (ctrl.load) begin
            cnt_next = '0;
        end
        if (emit) begin
            cnt_next      = cnt_reg + 1'b1;
            m_tvalid_next = 1'b1;
            m_char_next   = emit_char;
            m_tlast_next  = emit_last;
            m_cnt_next    = emit_last ? (cnt_reg + 1'b1) : '0;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg      <= UA_FETCH;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            upc_reg      <= upc_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_char_reg  <= m_char_next;
        m_cnt_reg   <= m_cnt_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, m_cnt_reg, m_char_reg};
    assign m_tlast  = m_tlast_reg;

endmodule

// ----- rtl/core/ita_urom.sv -----
// microcode rom of the integer to ascii formatter: one control word per step
// depends on ita_pkg
module ita_urom (
    input  ita_pkg::upc_t   addr,
    output ita_pkg::uword_t uword
);
    import ita_pkg::*;

    always_comb begin
        case (addr)
            UA_FETCH:    uword = '{ACT_FETCH,    1'b0, 1'b0, CH_NUL,    UA_FETCH,    UA_FETCH};
            UA_SDEC:     uword = '{ACT_EMIT_CHR, 1'b1, 1'b0, CH_MINUS,  UA_DEC_MUL,  UA_FETCH};
            UA_DEC_MUL:  uword = '{ACT_DEC_MUL,  1'b0, 1'b0, CH_NUL,    UA_DEC_DIG,  UA_FETCH};
            UA_DEC_DIG:  uword = '{ACT_DEC_DIG,  1'b0, 1'b0, CH_NUL,    UA_EMIT_DIG, UA_DEC_MUL};
            UA_HEX:      uword = '{ACT_HEX_DIG,  1'b0, 1'b0, CH_NUL,    UA_EMIT_DIG, UA_HEX};
            UA_EMIT_DIG: uword = '{ACT_EMIT_DIG, 1'b0, 1'b0, CH_NUL,    UA_FETCH,    UA_FETCH};
            UA_PTR:      uword = '{ACT_BR_ZERO,  1'b0, 1'b0, CH_NUL,    UA_PTR_0,    UA_NIL_0};
            UA_PTR_0:    uword = '{ACT_EMIT_CHR, 1'b0, 1'b0, CH_ZERO,   UA_PTR_X,    UA_FETCH};
            UA_PTR_X:    uword = '{ACT_EMIT_CHR, 1'b0, 1'b0, CH_X,      UA_HEX,      UA_FETCH};
            UA_NIL_0:    uword = '{ACT_EMIT_CHR, 1'b0, 1'b0, CH_LPAREN, UA_NIL_1,    UA_FETCH};
            UA_NIL_1:    uword = '{ACT_EMIT_CHR, 1'b0, 1'b0, CH_N,      UA_NIL_2,    UA_FETCH};
            UA_NIL_2:    uword = '{ACT_EMIT_CHR, 1'b0, 1'b0, CH_I,      UA_NIL_3,    UA_FETCH};
            UA_NIL_3:    uword = '{ACT_EMIT_CHR, 1'b0, 1'b0, CH_L,      UA_NIL_4,    UA_FETCH};
            UA_NIL_4:    uword = '{ACT_EMIT_CHR, 1'b0, 1'b1, CH_RPAREN, UA_FETCH,    UA_FETCH};
            default:     uword = '{ACT_FETCH,    1'b0, 1'b0, CH_NUL,    UA_FETCH,    UA_FETCH};
        endcase
    end

endmodule

// ----- rtl/core/ita_dpath.sv -----
// datapath of the integer to ascii formatter: value register, divide by ten
// via reciprocal multiply, and a digit stack; depends on ita_pkg
module ita_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ita_pkg::dp_ctrl_t             ctrl,
    input  logic [ita_pkg::OP_W-1:0]      op_in,
    input  logic [ita_pkg::VAL_W-1:0]     value_in,
    output ita_pkg::dp_stat_t             stat
);
    import ita_pkg::*;

    logic [OP_W-1:0]    op_reg,    op_next;
    logic               neg_reg,   neg_next;
    logic [VAL_W-1:0]   v_reg,     v_next;
    logic [Q_W-1:0]     q_reg,     q_next;
    logic [DIG_W-1:0]   stk_reg    [DEPTH];
    logic [DIG_W-1:0]   stk_next   [DEPTH];
    logic [DEPTH_W-1:0] depth_reg, depth_next;

    logic [31:0]        low32;
    logic               load_neg;
    logic [63:0]        prod;
    logic [DIG_W-1:0]   q10_lo;
    logic [DIG_W-1:0]   push_dig;
    logic               push;

    always_comb begin
        low32    = value_in[31:0];
        load_neg = (op_in == OP_SDEC) && low32[31];
        prod     = {32'b0, v_reg[31:0]} * {32'b0, RECIP10};
        // low nibble of 10*q is enough, the true remainder is below ten
        q10_lo   = {q_reg[0], 3'b000} + {q_reg[2:0], 1'b0};
        push     = ctrl.ddig || ctrl.hdig;
        push_dig = ctrl.ddig ? (v_reg[3:0] - q10_lo) : v_reg[3:0];
    end

    always_comb begin
        op_next    = op_reg;
        neg_next   = neg_reg;
        v_next     = v_reg;
        q_next     = q_reg;
        depth_next = depth_reg;
        stk_next   = stk_reg;
        if (ctrl.load) begin
            op_next    = op_in;
            neg_next   = load_neg;
            depth_next = '0;
            if (op_in == OP_POINTER) begin
                v_next = value_in & PTR_MASK;
            end else if (load_neg) begin
                v_next = {32'b0, (32'd0 - low32)};
            end else begin
                v_next = {32'b0, low32};
            end
        end
        if (ctrl.mul) begin
            q_next = prod[63:35];
        end
        if (ctrl.ddig) begin
            v_next = {{(VAL_W-Q_W){1'b0}}, q_reg};
        end
        if (ctrl.hdig) begin
            v_next = v_reg >> 4;
        end
        if (push) begin
            stk_next[0] = push_dig;
            for (int i = 1; i < DEPTH; i++) begin
                stk_next[i] = stk_reg[i-1];
            end
            depth_next = depth_reg + 1'b1;
        end
        if (ctrl.pop) begin
            for (int i = 0; i < DEPTH-1; i++) begin
                stk_next[i] = stk_reg[i+1];
            end
            depth_next = depth_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
        end else begin
            depth_reg <= depth_next;
        end
        op_reg  <= op_next;
        neg_reg <= neg_next;
        v_reg   <= v_next;
        q_reg   <= q_next;
        stk_reg <= stk_next;
    end

    always_comb begin
        stat.neg       = neg_reg;
        stat.v_zero    = (v_reg == '0);
        stat.q_nz      = (q_reg != '0);
        stat.hex_more  = (v_reg[VAL_W-1:4] != '0);
        stat.depth_one = (depth_reg == DEPTH_W'(1));
        stat.dig_char  = digit_char(stk_reg[0], op_reg == OP_HEX_UPPER);
    end

endmodule

// ----- rtl/core/ita_checker.sv -----
// port-level checker for the integer to ascii formatter, bound to the top
// level; depends only on the top level's ports
module ita_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // stalled transfer holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // count only on the final character, and never zero nor above 18 there
    a_cnt_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[12:8] != 5'd0 && m_tdata[12:8] <= 5'd18)
        else $error("bad character count on last");

    a_cnt_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[12:8] == 5'd0)
        else $error("character count on non-final character");

    // no new item while a run is still mid-way
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken during a run");

endmodule

bind integer_to_ascii_formatter ita_checker u_ita_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- tb/tb_top.sv -----
// self-checking testbench for integer_to_ascii_formatter: a directed table, then random
// format requests under three idle patterns and one long receiver hold-off
// depends on ita_pkg and the integer_to_ascii_formatter rtl only
module tb_top;
    import ita_pkg::*;

    // text of one run, held like a string literal: last character in the low byte
    localparam int MAX_CHARS = 18;
    typedef logic [8*MAX_CHARS-1:0] text_t;

    // operation codes the block leaves undefined
    localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_MID   = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

    localparam int DIR_N           = 24;
    localparam int RAND_PER_PHASE  = 32;
    localparam int HOLD_CYCLES     = 300;   // long receiver hold-off in the last phase
    localparam int DRAIN_CYCLES    = 60;    // quiet time after the last expected transfer
    localparam int RUN_LIMIT       = 400000;
    localparam int REPORT_MAX      = 10;

    // one expected output transfer
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
        logic [CNT_W-1:0]  count;
    } out_char_t;

    // one row of the directed table; given = 0 means the predictor supplies the text
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] value;
        logic             given;
        text_t            text;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;    // [63:0] value
    logic [2:0]  s_tuser = '0;    // [2:0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [7:0] character, [12:8] char_count, rest zero
    logic        m_tlast;

    out_char_t pending_chars[$];  // characters still owed by the block, oldest first
    int        err_cnt = 0;
    int        src_idle_pct = 0;
    int        sink_idle_pct = 0;
    logic      hold_req = 1'b0;   // asks the receiver process for one long hold-off
    logic      hold_done = 1'b0;  // the receiver has started that hold-off
    int        hold_left = 0;

    integer_to_ascii_formatter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // period of 2, first rising edge at time 1
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // run limit, also catches a block that stops answering
    initial begin
        #RUN_LIMIT;
        $display("RESULT: ERROR");
        $finish;
    end

    // expected text of one request, built from the low digit up
    function automatic text_t format_text(input logic [OP_W-1:0] op,
                                          input logic [VAL_W-1:0] value);
        text_t             txt;
        text_t             prefix;
        logic [VAL_W-1:0]  mag;
        logic [31:0]       low;
        logic [3:0]        dig;
        logic [CHAR_W-1:0] ch;
        logic              hex;
        logic              upper;
        int                n;
        txt    = '0;
        prefix = '0;
        hex    = 1'b0;
        upper  = 1'b0;
        n      = 0;
        low    = value[31:0];
        case (op)
            OP_SDEC: begin
                // negate in 32 bits, so the most negative value keeps its magnitude
                if (low[31]) begin
                    prefix = "-";
                    low    = 32'd0 - low;
                end
                mag = {32'b0, low};
            end
            OP_UDEC: begin
                mag = {32'b0, low};
            end
            OP_HEX_LOWER: begin
                mag = {32'b0, low};
                hex = 1'b1;
            end
            OP_HEX_UPPER: begin
                mag   = {32'b0, low};
                hex   = 1'b1;
                upper = 1'b1;
            end
            OP_POINTER: begin
                mag = value & PTR_MASK;
                if (mag == '0) begin
                    return "(nil)";
                end
                prefix = "0x";
                hex    = 1'b1;
            end
            default: begin
                // undefined operation: no characters at all
                return '0;
            end
        endcase
        do begin
            if (hex) begin
                dig = mag[3:0];
                mag = mag >> 4;
            end else begin
                dig = 4'(mag % 10);
                mag = mag / 10;
            end
            if (dig < 4'd10) begin
                ch = "0" + {4'b0, dig};
            end else begin
                ch = (upper ? "A" : "a") + {4'b0, dig} - 8'd10;
            end
            txt = txt | (text_t'(ch) << (8 * n));
            n++;
        end while (mag != '0);
        return txt | (prefix << (8 * n));
    endfunction

    // turn a text into the transfers it must produce; count rides on the final one
    task automatic queue_text(input text_t txt);
        out_char_t oc;
        int        len;
        len = 0;
        for (int k = 0; k < MAX_CHARS; k++) begin
            if (txt[8*k +: 8] != 8'h00) begin
                len = k + 1;
            end
        end
        for (int k = len - 1; k >= 0; k--) begin
            oc.code  = txt[8*k +: 8];
            oc.last  = (k == 0);
            oc.count = (k == 0) ? CNT_W'(len) : '0;
            pending_chars.push_back(oc);
        end
    endtask

    // offer one request, with a random gap first; expectations are queued on acceptance
    task automatic send_item(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value,
                             input text_t txt);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        queue_text(txt);
    endtask

    function automatic dir_row_t row(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value,
                                     input logic given, input text_t txt);
        dir_row_t r;
        r.op    = op;
        r.value = value;
        r.given = given;
        r.text  = txt;
        return r;
    endfunction

    // directed table: extremes, every operation, ignored high bits, undefined codes
    function automatic dir_row_t directed_row(input int idx);
        case (idx)
            0:  return row(OP_SDEC,       64'd0,                   1'b1, "0");
            1:  return row(OP_SDEC,       64'hFFFF_FFFF_8000_0000, 1'b1, "-2147483648");
            2:  return row(OP_SDEC,       64'h0000_0000_7FFF_FFFF, 1'b1, "2147483647");
            3:  return row(OP_SDEC,       64'h0000_0000_FFFF_FFFF, 1'b1, "-1");
            4:  return row(OP_SDEC,       64'h0000_0001_0000_0000, 1'b1, "0");
            5:  return row(OP_SDEC,       64'h5A5A_5A5A_1234_5678, 1'b0, '0);
            6:  return row(OP_UDEC,       64'd0,                   1'b1, "0");
            7:  return row(OP_UDEC,       64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "4294967295");
            8:  return row(OP_UDEC,       64'd9,                   1'b1, "9");
            9:  return row(OP_UDEC,       64'd10,                  1'b1, "10");
            10: return row(OP_UDEC,       64'd1000000000,          1'b0, '0);
            11: return row(OP_HEX_LOWER,  64'd0,                   1'b1, "0");
            12: return row(OP_HEX_LOWER,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "ffffffff");
            13: return row(OP_HEX_LOWER,  64'h0000_0000_ABCD_EF01, 1'b1, "abcdef01");
            14: return row(OP_HEX_UPPER,  64'h0000_0000_FFFF_FFFF, 1'b1, "FFFFFFFF");
            15: return row(OP_HEX_UPPER,  64'h0123_4567_89AB_CDEF, 1'b1, "89ABCDEF");
            16: return row(OP_HEX_UPPER,  64'h0000_0000_0000_000A, 1'b1, "A");
            17: return row(OP_POINTER,    64'd0,                   1'b1, "(nil)");
            18: return row(OP_POINTER,    64'd1,                   1'b1, "0x1");
            19: return row(OP_POINTER,    64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "0xffffffffffffffff");
            20: return row(OP_POINTER,    64'h8000_0000_0000_0000, 1'b1, "0x8000000000000000");
            21: return row(OP_POINTER,    64'h0000_7FFE_1234_5678, 1'b0, '0);
            22: return row(OP_RSVD_FIRST, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '0);
            default: return row((idx == DIR_N - 1) ? OP_RSVD_LAST : OP_RSVD_MID,
                                64'd12345, 1'b1, '0);
        endcase
    endfunction

    function automatic logic [OP_W-1:0] rand_op();
        // mostly defined operations, now and then an undefined code
        if ($urandom_range(9) == 0) begin
            return OP_W'($urandom_range(OP_RSVD_LAST, OP_RSVD_FIRST));
        end
        return OP_W'($urandom_range(OP_POINTER, OP_SDEC));
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        logic [VAL_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(3))
            0: v = v >> $urandom_range(63);                 // spread of digit counts
            1: v = v;                                       // full width
            2: v = {v[63:32], 32'($urandom_range(20))};     // short text, junk above
            default: v = {v[63:32], ($urandom_range(1) != 0) ? 32'h8000_0000
                                                             : 32'hFFFF_FFFF};
        endcase
        return v;
    endfunction

    // receiver: random stalls, or one long counted hold-off when asked
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // output checker: every transfer against the oldest expected character
    always @(posedge aclk) begin : check_out
        out_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_chars.size() == 0) begin
                if (err_cnt < REPORT_MAX) begin
                    $display("unexpected transfer: char %h last %b count %0d",
                             m_tdata[7:0], m_tlast, m_tdata[12:8]);
                end
                err_cnt++;
            end else begin
                want = pending_chars.pop_front();
                if (m_tdata[7:0] !== want.code || m_tlast !== want.last ||
                    m_tdata[12:8] !== want.count) begin
                    if (err_cnt < REPORT_MAX) begin
                        $display({"mismatch: expected char %h last %b count %0d, ",
                                  "got char %h last %b count %0d"},
                                 want.code, want.last, want.count,
                                 m_tdata[7:0], m_tlast, m_tdata[12:8]);
                    end
                    err_cnt++;
                end
            end
        end
    end

    // stimulus: reset, directed table, then three phases of random requests
    initial begin : stimulus
        dir_row_t         r;
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] value;
        src_idle_pct  <= 15;
        sink_idle_pct <= 54;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_N; i++) begin
            r = directed_row(i);
            send_item(r.op, r.value, r.given ? r.text : format_text(r.op, r.value));
        end

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct  <= 15;
                    sink_idle_pct <= 54;
                end
                1: begin
                    src_idle_pct  <= 54;
                    sink_idle_pct <= 15;
                end
                default: begin
                    // no idling; the receiver holds off while requests keep coming
                    src_idle_pct  <= 0;
                    sink_idle_pct <= 0;
                    hold_req      <= 1'b1;
                end
            endcase
            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                op    = rand_op();
                value = rand_value();
                send_item(op, value, format_text(op, value));
            end
        end
        s_tvalid <= 1'b0;

        // drain, then give trailing extra transfers time to show up
        while (pending_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_cnt == 0 && pending_chars.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
